// File: hw/rtl/csp_pkg.sv
// Shared types and constants for the counting semaphore with priority waiters.
// No dependencies; every other file of the block imports this package.
package csp_pkg;

	localparam int TASK_W    = 8;
	localparam int PRIO_W    = 5;
	localparam int COUNT_W   = 16;
	localparam int STATUS_W  = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		ACT_TAKE   = 2'd0,
		ACT_GIVE   = 2'd1,
		ACT_RESET  = 2'd2,
		ACT_CANCEL = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED    = 4'd0,
		ST_BUSY       = 4'd1,
		ST_QUEUED     = 4'd2,
		ST_QUEUE_FULL = 4'd3,
		ST_GIVE_WOKE  = 4'd4,
		ST_RESET_WOKE = 4'd5,
		ST_COUNTED    = 4'd6,
		ST_AT_LIMIT   = 4'd7,
		ST_CANCELLED  = 4'd8,
		ST_NOT_QUEUED = 4'd9,
		ST_RESET_IDLE = 4'd10
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_LIMIT   = 1'd0,
		REG_INITIAL_COUNT = 1'd1
	} cfg_reg_t;

	typedef logic [TASK_W-1:0]  task_id_t;
	typedef logic [PRIO_W-1:0]  prio_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

// File: hw/rtl/csp_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on csp_pkg for payload types.
interface csp_req_if;
	import csp_pkg::*;
	logic     valid;
	logic     ready;
	action_t  action;
	task_id_t task_id;
	prio_t    priority_req;
	logic     no_wait;
	modport source (output valid, action, task_id, priority_req, no_wait, input ready);
	modport sink   (input valid, action, task_id, priority_req, no_wait, output ready);
endinterface

interface csp_rsp_if;
	import csp_pkg::*;
	logic     valid;
	logic     ready;
	status_t  status;
	task_id_t woken_task;
	count_t   count_now;
	logic     last;
	modport source (output valid, status, woken_task, count_now, last, input ready);
	modport sink   (input valid, status, woken_task, count_now, last, output ready);
endinterface

interface csp_cfg_if;
	import csp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	count_t               data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/counting_semaphore_priority_waiters.sv
// Counting semaphore with a saturating limit and a priority-ordered waiter queue.
// Take, plain give and idle reset respond from S_EXEC through S_EMIT; cancel scans the queue
// up to the matching entry or its end, and a give that wakes a waiter scans every entry first.
// Reset wakes every waiter, one scan of the shared compare per wake.
// One request at a time; a stalled response holds it.
// arst_n clears count, limit (to 1), initial count and the queue; entries are not cleared.
module counting_semaphore_priority_waiters #(
	parameter int MAX_WAITERS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	csp_req_if.sink    req,
	csp_rsp_if.source  rsp,
	csp_cfg_if.sink    cfg
);
	import csp_pkg::*;

	localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CNT_W = $clog2(MAX_WAITERS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAITERS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_REMOVE,
		S_EMIT
	} state_t;

	state_t           state_q;
	action_t          act_q;
	task_id_t         tid_q;
	prio_t            prio_q;
	logic             nw_q;
	count_t           limit_q;
	count_t           init_q;
	count_t           count_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] rm_idx_q;
	prio_t            best_prio_q;
	task_id_t         best_task_q;
	status_t          res_status_q;
	task_id_t         res_task_q;
	logic             res_last_q;
	logic             out_valid_q;
	status_t          out_status_q;
	task_id_t         out_task_q;
	count_t           out_count_q;
	logic             out_last_q;

	task_id_t waiter_task_q [MAX_WAITERS];
	prio_t    waiter_prio_q [MAX_WAITERS];

	task_id_t rd_task;
	prio_t    rd_prio;
	logic     scan_more;
	logic     append_ok;
	logic     out_free;
	count_t   new_limit;
	count_t   new_init;

	assign rd_task   = waiter_task_q[idx_q[IDX_W-1:0]];
	assign rd_prio   = waiter_prio_q[idx_q[IDX_W-1:0]];
	assign scan_more = idx_q < total_q;
	assign append_ok = (count_q == '0) && !nw_q && (total_q != MAX_CNT);
	assign out_free  = !out_valid_q || rsp.ready;

	assign new_limit = (cfg.index == REG_COUNT_LIMIT)   ? cfg.data : limit_q;
	assign new_init  = (cfg.index == REG_INITIAL_COUNT) ? cfg.data : init_q;

	assign req.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.woken_task = out_task_q;
	assign rsp.count_now  = out_count_q;
	assign rsp.last       = out_last_q;

	// Queue entries: append at the tail, close the gap on removal.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && act_q == ACT_TAKE && append_ok) begin
			waiter_task_q[total_q[IDX_W-1:0]] <= tid_q;
			waiter_prio_q[total_q[IDX_W-1:0]] <= prio_q;
		end else if (state_q == S_REMOVE) begin
			for (int i = 0; i < MAX_WAITERS - 1; i++) begin
				if (IDX_W'(i) >= rm_idx_q) begin
					waiter_task_q[i] <= waiter_task_q[i + 1];
					waiter_prio_q[i] <= waiter_prio_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= COUNT_W'(1);
			init_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// S_EMIT drives the response valid itself
			if (rsp.ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			if (cfg.valid) begin
				if (cfg.index == REG_COUNT_LIMIT)
					limit_q <= cfg.data;
				if (cfg.index == REG_INITIAL_COUNT)
					init_q <= cfg.data;
				count_q <= (new_init > new_limit) ? new_limit : new_init;
				total_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q   <= req.action;
						tid_q   <= req.task_id;
						prio_q  <= req.priority_req;
						nw_q    <= req.no_wait;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_task_q <= '0;
					res_last_q <= 1'b1;
					idx_q      <= '0;
					state_q    <= S_EMIT;
					case (act_q)
						ACT_TAKE: begin
							if (count_q != '0) begin
								count_q      <= count_q - COUNT_W'(1);
								res_status_q <= ST_GRANTED;
							end else if (nw_q) begin
								res_status_q <= ST_BUSY;
							end else if (total_q == MAX_CNT) begin
								res_status_q <= ST_QUEUE_FULL;
							end else begin
								total_q      <= total_q + CNT_W'(1);
								res_status_q <= ST_QUEUED;
							end
						end
						ACT_GIVE: begin
							if (total_q != '0) begin
								state_q <= S_SCAN;
							end else if (count_q < limit_q) begin
								count_q      <= count_q + COUNT_W'(1);
								res_status_q <= ST_COUNTED;
							end else begin
								res_status_q <= ST_AT_LIMIT;
							end
						end
						ACT_RESET: begin
							count_q <= '0;
							if (total_q != '0)
								state_q <= S_SCAN;
							else
								res_status_q <= ST_RESET_IDLE;
						end
						default: begin
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (act_q == ACT_CANCEL) begin
						if (!scan_more) begin
							res_status_q <= ST_NOT_QUEUED;
							res_task_q   <= '0;
							res_last_q   <= 1'b1;
							state_q      <= S_EMIT;
						end else if (rd_task == tid_q) begin
							rm_idx_q     <= idx_q[IDX_W-1:0];
							res_status_q <= ST_CANCELLED;
							res_task_q   <= tid_q;
							state_q      <= S_REMOVE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						if (scan_more) begin
							// first entry seeds the best; later ones win only on strictly higher
							if (idx_q == '0 || rd_prio > best_prio_q) begin
								rm_idx_q    <= idx_q[IDX_W-1:0];
								best_prio_q <= rd_prio;
								best_task_q <= rd_task;
							end
							idx_q <= idx_q + CNT_W'(1);
						end else begin
							res_status_q <= (act_q == ACT_GIVE) ? ST_GIVE_WOKE : ST_RESET_WOKE;
							res_task_q   <= best_task_q;
							state_q      <= S_REMOVE;
						end
					end
				end
				S_REMOVE: begin
					total_q    <= total_q - CNT_W'(1);
					res_last_q <= (act_q != ACT_RESET) || (total_q == CNT_W'(1));
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_task_q   <= res_task_q;
						out_count_q  <= count_q;
						out_last_q   <= res_last_q;
						idx_q        <= '0;
						// keep draining the queue on reset
						state_q      <= res_last_q ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/csp_checker.sv
// Port-level checks for counting_semaphore_priority_waiters, attached by bind.
// Depends on csp_pkg for status codes.
module csp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [3:0] rsp_status,
	input logic [7:0] rsp_woken_task,
	input logic [15:0] rsp_count_now,
	input logic       rsp_last
);
	import csp_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_woken_task) && $stable(rsp_count_now) && $stable(rsp_last))
		else $error("response changed while stalled");

	// busy after a request transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !(rsp_status == ST_GIVE_WOKE || rsp_status == ST_RESET_WOKE
			|| rsp_status == ST_CANCELLED) |-> rsp_woken_task == '0)
		else $error("woken task set on a status without one");

	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_RESET_WOKE || rsp_status == ST_RESET_IDLE)
			|-> rsp_count_now == '0)
		else $error("reset response with nonzero count");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !(rsp_status == ST_RESET_WOKE) |-> rsp_last)
		else $error("single response without last");

endmodule

bind counting_semaphore_priority_waiters csp_checker u_csp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_woken_task (rsp.woken_task),
	.rsp_count_now  (rsp.count_now),
	.rsp_last       (rsp.last)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for counting_semaphore_priority_waiters: directed and random
// take/give/reset/cancel traffic, checked against a scoreboard that predicts every response.
// Depends on csp_pkg and the csp_*_if interfaces of the RTL.
module tb_top;
	import csp_pkg::*;

	localparam int QUEUE_DEPTH = 16;

	typedef struct packed {
		status_t  status;
		task_id_t woken_task;
		count_t   count_now;
		logic     last;
	} sem_result_t;

	typedef bit bool_found_t;

	class semaphore_scoreboard;
		count_t      limit_reg;
		count_t      init_reg;
		count_t      sem_count;
		task_id_t    wq_task [QUEUE_DEPTH];
		prio_t       wq_prio [QUEUE_DEPTH];
		int          wq_len;
		sem_result_t awaited_q [$];
		int          errors;

		function void reinit();
			sem_count = (init_reg > limit_reg) ? limit_reg : init_reg;
			wq_len = 0;
		endfunction

		function void power_on();
			limit_reg = 1;
			init_reg = 0;
			errors = 0;
			reinit();
		endfunction

		function void write_reg(cfg_reg_t idx, count_t value);
			case (idx)
				REG_COUNT_LIMIT:   limit_reg = value;
				REG_INITIAL_COUNT: init_reg = value;
				default: ;
			endcase
			reinit();
		endfunction

		function void push_result(status_t st, task_id_t tid, logic fin);
			sem_result_t r;
			r.status = st;
			r.woken_task = tid;
			r.count_now = sem_count;
			r.last = fin;
			awaited_q.push_back(r);
		endfunction

		function void drop_waiter(int k);
			for (int i = k; i + 1 < wq_len; i++) begin
				wq_task[i] = wq_task[i + 1];
				wq_prio[i] = wq_prio[i + 1];
			end
			wq_len--;
		endfunction

		// highest priority wins, earliest arrival among equals
		function task_id_t pop_best_waiter();
			int       best;
			task_id_t tid;
			best = 0;
			for (int i = 1; i < wq_len; i++)
				if (wq_prio[i] > wq_prio[best])
					best = i;
			tid = wq_task[best];
			drop_waiter(best);
			return tid;
		endfunction

		function void note_request(action_t act, task_id_t tid, prio_t pr, logic nw);
			bool_found_t found;
			found = 0;
			case (act)
				ACT_TAKE: begin
					if (sem_count != 0) begin
						sem_count--;
						push_result(ST_GRANTED, '0, 1'b1);
					end else if (nw) begin
						push_result(ST_BUSY, '0, 1'b1);
					end else if (wq_len >= QUEUE_DEPTH) begin
						push_result(ST_QUEUE_FULL, '0, 1'b1);
					end else begin
						wq_task[wq_len] = tid;
						wq_prio[wq_len] = pr;
						wq_len++;
						push_result(ST_QUEUED, '0, 1'b1);
					end
				end
				ACT_GIVE: begin
					if (wq_len != 0) begin
						push_result(ST_GIVE_WOKE, pop_best_waiter(), 1'b1);
					end else if (sem_count < limit_reg) begin
						sem_count++;
						push_result(ST_COUNTED, '0, 1'b1);
					end else begin
						push_result(ST_AT_LIMIT, '0, 1'b1);
					end
				end
				ACT_RESET: begin
					sem_count = 0;
					if (wq_len == 0)
						push_result(ST_RESET_IDLE, '0, 1'b1);
					while (wq_len != 0) begin
						task_id_t woke;
						woke = pop_best_waiter();
						push_result(ST_RESET_WOKE, woke, wq_len == 0);
					end
				end
				default: begin
					// only the earliest entry of a duplicated id goes
					for (int i = 0; i < wq_len && !found; i++) begin
						if (wq_task[i] == tid) begin
							drop_waiter(i);
							push_result(ST_CANCELLED, tid, 1'b1);
							found = 1;
						end
					end
					if (!found)
						push_result(ST_NOT_QUEUED, '0, 1'b1);
				end
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(status_t st, task_id_t tid, count_t cnt, logic fin);
			sem_result_t exp_r;
			if (awaited_q.size() == 0) begin
				report($sformatf("unexpected response status=%0d task=%0d count=%0d",
					st, tid, cnt));
				return;
			end
			exp_r = awaited_q.pop_front();
			if (st !== exp_r.status)
				report($sformatf("status %0d, want %0d", st, exp_r.status));
			if (tid !== exp_r.woken_task)
				report($sformatf("woken_task %0d, want %0d", tid, exp_r.woken_task));
			if (cnt !== exp_r.count_now)
				report($sformatf("count_now %0d, want %0d", cnt, exp_r.count_now));
			if (fin !== exp_r.last)
				report($sformatf("last %0b, want %0b", fin, exp_r.last));
		endtask

		function int awaited();
			return awaited_q.size();
		endfunction

		function task_id_t any_waiter();
			return wq_task[$urandom_range(wq_len - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   gap_pct;
	int   stall_pct;

	semaphore_scoreboard sb;

	csp_req_if req_ch ();
	csp_rsp_if rsp_ch ();
	csp_cfg_if cfg_ch ();

	counting_semaphore_priority_waiters #(.MAX_WAITERS(QUEUE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// valid and ready are stable from the falling edge up to the transfer edge
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.woken_task, rsp_ch.count_now, rsp_ch.last);
	end

	task automatic send_request(action_t act, task_id_t tid, prio_t pr, logic nw);
		logic took;
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.task_id      <= tid;
		req_ch.priority_req <= pr;
		req_ch.no_wait      <= nw;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			@(posedge clk);
		end while (!took);
		sb.note_request(act, tid, pr, nw);
	endtask

	task automatic write_config(cfg_reg_t idx, count_t value);
		logic took;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(negedge clk);
			took = cfg_ch.ready;
			@(posedge clk);
		end while (!took);
		cfg_ch.valid <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.awaited() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pressure(int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 63; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 63; end
			default: begin gap_pct = 33; stall_pct = 33; end
		endcase
	endtask

	// queue-building takes most often, with gives, cancels mostly of live waiters and rare resets
	task automatic random_item();
		int       pick;
		task_id_t tid;
		prio_t    pr;
		logic     nw;
		pick = $urandom_range(99);
		tid = $urandom_range(1) ? task_id_t'($urandom_range(255)) : task_id_t'($urandom_range(7));
		pr = $urandom_range(2) ? prio_t'($urandom_range(31)) : prio_t'(16);
		nw = ($urandom_range(99) < 15);
		if (pick < 45) begin
			send_request(ACT_TAKE, tid, pr, nw);
		end else if (pick < 72) begin
			send_request(ACT_GIVE, tid, pr, nw);
		end else if (pick < 92) begin
			if (sb.wq_len != 0 && $urandom_range(3) != 0)
				tid = sb.any_waiter();
			send_request(ACT_CANCEL, tid, pr, nw);
		end else begin
			send_request(ACT_RESET, tid, pr, nw);
		end
	endtask

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		count_t   seg_limit [6];
		count_t   seg_init  [6];
		int       seg_items [6];
		task_id_t tid;
		prio_t    pr;

		seg_limit = '{16'd65535, 16'd3, 16'd1, 16'd2, 16'd6, 16'd4};
		seg_init  = '{16'd65535, 16'd1, 16'd0, 16'd40000, 16'd0, 16'd4};
		seg_items = '{30, 68, 68, 68, 68, 68};

		sb = new();
		sb.power_on();
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_TAKE;
		req_ch.task_id = '0;
		req_ch.priority_req = '0;
		req_ch.no_wait = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		set_pressure(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero limit: nothing can be counted, every blocking take queues while there is room
		write_config(REG_COUNT_LIMIT, 16'd0);
		write_config(REG_INITIAL_COUNT, 16'd0);
		send_request(ACT_GIVE, 8'd0, 5'd0, 1'b0);
		send_request(ACT_TAKE, 8'd12, 5'd3, 1'b1);
		send_request(ACT_CANCEL, 8'd99, 5'd0, 1'b0);
		send_request(ACT_RESET, 8'd0, 5'd0, 1'b0);
		// fill the queue with ties and a duplicate id, then one take too many
		for (int k = 0; k <= QUEUE_DEPTH; k++) begin
			tid = task_id_t'(k * 37);
			pr = prio_t'(k * 7);
			case (k)
				0: begin tid = 8'd255; pr = 5'd31; end
				1: begin tid = 8'd0;   pr = 5'd0;  end
				2: begin tid = 8'd7;   pr = 5'd31; end
				3: begin tid = 8'd7;   pr = 5'd5;  end
				default: ;
			endcase
			send_request(ACT_TAKE, tid, pr, 1'b0);
		end
		send_request(ACT_CANCEL, 8'd7, 5'd0, 1'b0);
		send_request(ACT_GIVE, 8'd0, 5'd0, 1'b0);
		send_request(ACT_RESET, 8'd0, 5'd0, 1'b0);

		for (int seg = 0; seg < 6; seg++) begin
			drain();
			set_pressure(seg % 4);
			write_config(REG_COUNT_LIMIT, seg_limit[seg]);
			write_config(REG_INITIAL_COUNT, seg_init[seg]);
			repeat (seg_items[seg]) random_item();
		end

		drain();
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.awaited() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
